/* rtl/lae_pkg.sv */
// ============================================================================
// lae_pkg
// Shared constants and types for the cellular automaton engine: board limits,
// request codes, configuration register indexes and the row type.
// ============================================================================
package lae_pkg;

    // Board limits; one memory word holds one full row of the board.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 64;

    localparam int COL_W     = 8;                    // column field width
    localparam int ROW_AW    = $clog2(MAX_HEIGHT);   // row address width
    localparam int ROW_CNT_W = ROW_AW + 1;           // row counter, holds MAX_HEIGHT

    // Configuration registers
    localparam int WIDTH_REG_W  = 9;
    localparam int HEIGHT_REG_W = 7;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_HEIGHT = 1'd1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 9'd150;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 7'd60;

    // Request and response codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_ADVANCE = 2'd2;

    // Rule B3/S23
    localparam logic [3:0] LIFE_BIRTH   = 4'd3;
    localparam logic [3:0] LIFE_SURVIVE = 4'd2;

    typedef logic [MAX_WIDTH-1:0] row_t;

endpackage

/* rtl/lae_if.sv */
// ============================================================================
// lae_if
// Valid/ready channels of the automaton engine: the request channel and the
// response channel.
// ============================================================================
interface lae_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [lae_pkg::COL_W-1:0] col;
    logic [lae_pkg::ROW_AW-1:0] row;
    logic                      cell_in;

    modport source (output valid, output req_type, output col, output row,
                    output cell_in, input ready);
    modport sink   (input valid, input req_type, input col, input row,
                    input cell_in, output ready);
endinterface

interface lae_resp_if;
    logic       valid;
    logic       ready;
    logic [1:0] resp_kind;
    logic       cell_out;
    logic       range_error;

    modport source (output valid, output resp_kind, output cell_out,
                    output range_error, input ready);
    modport sink   (input valid, input resp_kind, input cell_out,
                    input range_error, output ready);
endinterface

/* rtl/lae_ram.sv */
// ============================================================================
// lae_ram
// Generic simple dual-port RAM: one write port, one read port, read data registered.
// ============================================================================
module lae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lae_row_update.sv */
// ============================================================================
// lae_row_update
// Next-generation row: applies rule B3/S23 to every column of one row from
// the rows above, at and below it. Cells past either end count as dead.
// ============================================================================
module lae_row_update (
    input  lae_pkg::row_t up_row,
    input  lae_pkg::row_t mid_row,
    input  lae_pkg::row_t down_row,
    input  lae_pkg::row_t col_mask,
    input  logic          row_valid,
    output lae_pkg::row_t next_row
);

    logic [lae_pkg::MAX_WIDTH+1:0] up_x;
    logic [lae_pkg::MAX_WIDTH+1:0] mid_x;
    logic [lae_pkg::MAX_WIDTH+1:0] down_x;

    assign up_x   = {1'b0, up_row, 1'b0};
    assign mid_x  = {1'b0, mid_row, 1'b0};
    assign down_x = {1'b0, down_row, 1'b0};

    // Each column is independent: count its eight neighbours and decide.
    always_comb
    begin
        logic [3:0] cnt;
        cnt      = '0;
        next_row = '0;
        for (int i = 0; i < lae_pkg::MAX_WIDTH; i++)
        begin
            cnt = 4'(up_x[i]) + 4'(up_x[i+1]) + 4'(up_x[i+2])
                + 4'(mid_x[i]) + 4'(mid_x[i+2])
                + 4'(down_x[i]) + 4'(down_x[i+1]) + 4'(down_x[i+2]);
            if (mid_row[i])
            begin
                next_row[i] = (cnt == lae_pkg::LIFE_SURVIVE) || (cnt == lae_pkg::LIFE_BIRTH);
            end
            else
            begin
                next_row[i] = (cnt == lae_pkg::LIFE_BIRTH);
            end
            next_row[i] = next_row[i] & col_mask[i] & row_valid;
        end
    end

endmodule

/* rtl/life_automaton_engine.sv */
// ============================================================================
// life_automaton_engine
// Game of Life (B3/S23) on a bounded, double-buffered board held in two
// row-wide synchronous memories.
// ============================================================================
// Usage:
//   Requests arrive on the req channel (valid/ready); each transaction writes
//   one cell, reads one cell or advances the whole board one generation.
//   Every request yields exactly one transaction on the resp channel, in order.
//   The board size comes from the cfg port (cfg_we, cfg_index, cfg_data);
//   change it only while no request is outstanding.
// Flow:
//   A read or write passes through ACCESS and then RESP after acceptance: the row is
//   read from the current bank, then modified and written back or picked.
//   Off-board and unknown requests go from acceptance straight to RESP.
//   A generation sweeps the rows in ST_GEN: one 256-bit row of the
//   source bank is read per cycle and one row of the other bank is written.
//   Requests are processed one at a time; ready is high in the idle state.
// Reset:
//   rst_n clears both banks with a pass over all MAX_HEIGHT = 64 rows, writing one
//   row of each bank per cycle; no request is accepted meanwhile.
// Back-pressure:
//   The response register holds its transaction until taken. A new request
//   may be accepted while it waits; its own response waits behind it.
// ============================================================================
module life_automaton_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    lae_req_if.sink                          req,
    lae_resp_if.source                       resp,
    input  logic                             cfg_we,
    input  logic [lae_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lae_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = lae_pkg::ROW_AW;
    localparam int CW = lae_pkg::ROW_CNT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_GEN,
        ST_RESP
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers and effective board size (saturated)
    // ------------------------------------------------------------------
    logic [lae_pkg::WIDTH_REG_W-1:0]  board_width_reg;
    logic [lae_pkg::HEIGHT_REG_W-1:0] board_height_reg;
    logic [lae_pkg::WIDTH_REG_W-1:0]  eff_w;
    logic [lae_pkg::HEIGHT_REG_W-1:0] eff_h;
    lae_pkg::row_t                    col_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_width_reg  <= lae_pkg::WIDTH_RESET;
            board_height_reg <= lae_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lae_pkg::CFG_BOARD_WIDTH:
                    board_width_reg <= cfg_data[lae_pkg::WIDTH_REG_W-1:0];
                lae_pkg::CFG_BOARD_HEIGHT:
                    board_height_reg <= cfg_data[lae_pkg::HEIGHT_REG_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        if (board_width_reg == '0)
            eff_w = lae_pkg::WIDTH_REG_W'(1);
        else if (board_width_reg > lae_pkg::WIDTH_REG_W'(lae_pkg::MAX_WIDTH))
            eff_w = lae_pkg::WIDTH_REG_W'(lae_pkg::MAX_WIDTH);
        else
            eff_w = board_width_reg;

        if (board_height_reg == '0)
            eff_h = lae_pkg::HEIGHT_REG_W'(1);
        else if (board_height_reg > lae_pkg::HEIGHT_REG_W'(lae_pkg::MAX_HEIGHT))
            eff_h = lae_pkg::HEIGHT_REG_W'(lae_pkg::MAX_HEIGHT);
        else
            eff_h = board_height_reg;
    end

    // Columns in use; cells beyond are dead on read and on write-back.
    always_comb
    begin
        for (int i = 0; i < lae_pkg::MAX_WIDTH; i++)
        begin
            col_mask[i] = (lae_pkg::WIDTH_REG_W'(i) < eff_w);
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                    state_reg,     state_next;
    logic [AW-1:0]             clr_cnt_reg,   clr_cnt_next;
    logic [CW-1:0]             k_reg,         k_next;       // source row arriving
    logic                      cur_bank_reg,  cur_bank_next; // 0: bank A holds board
    logic [1:0]                kind_reg,      kind_next;
    logic [lae_pkg::COL_W-1:0] col_reg,       col_next;
    logic [AW-1:0]             row_reg,       row_next;
    logic                      cell_in_reg,   cell_in_next;
    logic                      pend_cell_reg, pend_cell_next;
    logic                      pend_err_reg,  pend_err_next;
    lae_pkg::row_t             up_reg,        up_next;
    lae_pkg::row_t             mid_reg,       mid_next;
    logic                      resp_valid_reg, resp_valid_next;
    logic [1:0]                resp_kind_reg,  resp_kind_next;
    logic                      resp_cell_reg,  resp_cell_next;
    logic                      resp_err_reg,   resp_err_next;

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic          clr_we, we_cur, we_oth;
    logic          we_a, we_b;
    logic [AW-1:0] waddr, raddr;
    lae_pkg::row_t wdata;
    lae_pkg::row_t rdata_a, rdata_b, cur_rdata;
    lae_pkg::row_t row_mod, below_row, gen_row;
    logic          gen_row_ok;
    logic          off_board;

    assign cur_rdata = cur_bank_reg ? rdata_b : rdata_a;

    // Clearing writes both banks; cell writes go to the current bank,
    // generation results to the other one.
    assign we_a = clr_we | (we_cur & ~cur_bank_reg) | (we_oth & cur_bank_reg);
    assign we_b = clr_we | (we_cur & cur_bank_reg) | (we_oth & ~cur_bank_reg);

    lae_ram #(
        .WIDTH (lae_pkg::MAX_WIDTH),
        .DEPTH (lae_pkg::MAX_HEIGHT)
    ) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    lae_ram #(
        .WIDTH (lae_pkg::MAX_WIDTH),
        .DEPTH (lae_pkg::MAX_HEIGHT)
    ) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    // Read-modify-write of one cell within its row
    always_comb
    begin
        row_mod          = cur_rdata;
        row_mod[col_reg] = cell_in_reg;
    end

    // Row below the one being computed; zero once past the board's last row
    assign below_row  = (k_reg < CW'(eff_h)) ? (cur_rdata & col_mask) : '0;
    // Row k-1 is written; rows past the board are written dead
    assign gen_row_ok = (k_reg <= CW'(eff_h));

    lae_row_update u_row_update (
        .up_row    (up_reg),
        .mid_row   (mid_reg),
        .down_row  (below_row),
        .col_mask  (col_mask),
        .row_valid (gen_row_ok),
        .next_row  (gen_row)
    );

    assign off_board = ({1'b0, req.col} >= eff_w) || ({1'b0, req.row} >= eff_h);

    assign req.ready = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        k_next          = k_reg;
        cur_bank_next   = cur_bank_reg;
        kind_next       = kind_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        cell_in_next    = cell_in_reg;
        pend_cell_next  = pend_cell_reg;
        pend_err_next   = pend_err_reg;
        up_next         = up_reg;
        mid_next        = mid_reg;
        resp_valid_next = resp_valid_reg;
        resp_kind_next  = resp_kind_reg;
        resp_cell_next  = resp_cell_reg;
        resp_err_next   = resp_err_reg;
        clr_we          = 1'b0;
        we_cur          = 1'b0;
        we_oth          = 1'b0;
        waddr           = '0;
        wdata           = '0;
        raddr           = '0;

        // Drop the response once taken; a reload below overrides this.
        if (resp.ready)
        begin
            resp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_we       = 1'b1;
                waddr        = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(lae_pkg::MAX_HEIGHT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                // Issue the read with the request; the row arrives next cycle.
                raddr = (req.req_type == lae_pkg::REQ_ADVANCE) ? '0 : req.row;
                if (req.valid)
                begin
                    kind_next      = req.req_type;
                    col_next       = req.col;
                    row_next       = req.row;
                    cell_in_next   = req.cell_in;
                    pend_cell_next = 1'b0;
                    pend_err_next  = 1'b0;
                    case (req.req_type) inside
                        lae_pkg::REQ_WRITE, lae_pkg::REQ_READ:
                        begin
                            if (off_board)
                            begin
                                pend_err_next = 1'b1;
                                state_next    = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_ACCESS;
                            end
                        end
                        lae_pkg::REQ_ADVANCE:
                        begin
                            k_next     = '0;
                            up_next    = '0;
                            mid_next   = '0;
                            state_next = ST_GEN;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_ACCESS:
            begin
                if (kind_reg == lae_pkg::REQ_WRITE)
                begin
                    we_cur = 1'b1;
                    waddr  = row_reg;
                    wdata  = row_mod;
                end
                else
                begin
                    pend_cell_next = cur_rdata[col_reg];
                end
                state_next = ST_RESP;
            end

            ST_GEN:
            begin
                // Row k arrives; write row k-1 of the other bank, fetch k+1.
                raddr    = k_reg[AW-1:0] + 1'b1;
                we_oth   = (k_reg != '0);
                waddr    = AW'(k_reg - 1'b1);
                wdata    = gen_row;
                up_next  = mid_reg;
                mid_next = below_row;
                k_next   = k_reg + 1'b1;
                if (k_reg == CW'(lae_pkg::MAX_HEIGHT))
                begin
                    cur_bank_next = ~cur_bank_reg;
                    state_next    = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (!resp_valid_reg || resp.ready)
                begin
                    resp_valid_next = 1'b1;
                    resp_kind_next  = kind_reg;
                    resp_cell_next  = pend_cell_reg;
                    resp_err_next   = pend_err_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            k_reg          <= '0;
            cur_bank_reg   <= 1'b0;
            kind_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            cell_in_reg    <= 1'b0;
            pend_cell_reg  <= 1'b0;
            pend_err_reg   <= 1'b0;
            up_reg         <= '0;
            mid_reg        <= '0;
            resp_valid_reg <= 1'b0;
            resp_kind_reg  <= '0;
            resp_cell_reg  <= 1'b0;
            resp_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            k_reg          <= k_next;
            cur_bank_reg   <= cur_bank_next;
            kind_reg       <= kind_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            cell_in_reg    <= cell_in_next;
            pend_cell_reg  <= pend_cell_next;
            pend_err_reg   <= pend_err_next;
            up_reg         <= up_next;
            mid_reg        <= mid_next;
            resp_valid_reg <= resp_valid_next;
            resp_kind_reg  <= resp_kind_next;
            resp_cell_reg  <= resp_cell_next;
            resp_err_reg   <= resp_err_next;
        end
    end

    assign resp.valid       = resp_valid_reg;
    assign resp.resp_kind   = resp_kind_reg;
    assign resp.cell_out    = resp_cell_reg;
    assign resp.range_error = resp_err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Banks swap only at the end of a generation sweep.
    a_swap_at_gen_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_bank_reg != $past(cur_bank_reg)) |->
            ($past(state_reg) == ST_GEN && $past(k_reg) == CW'(lae_pkg::MAX_HEIGHT)))
        else $error("bank swap outside the end of a generation");

    // Both banks are written together only by the clearing pass.
    a_dual_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (we_a && we_b) |-> (state_reg == ST_CLEAR))
        else $error("both banks written outside the clearing pass");

    // Generation rows past the board's last row are written dead.
    a_gen_offboard_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GEN && we_oth && {1'b0, waddr} >= eff_h) |-> (wdata == '0))
        else $error("live cell written past the board in a generation");

    // An out-of-range response never carries a live cell.
    a_error_reads_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid_reg && resp_err_reg) |-> !resp_cell_reg)
        else $error("range error response with a live cell");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the life automaton engine. A local board predictor
// (double-buffered, B3/S23, edges dead) computes the response of every
// accepted request. A monitor compares each response transaction field by
// field, in order. A directed part covers corners, off-board accesses,
// register saturation, the unused request code and small known patterns.
// A random part then runs clustered writes, generations and reads on
// mostly small boards, with noise mixed in and random idling on both sides.
// ============================================================================
module tb_top;

    // Request code the engine does not define; it must still answer.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Cycles without any accepted transaction before the run is abandoned.
    // The longest legal gap is a generation plus a stalled
    // receiver; this is many times that.
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [lae_pkg::COL_W-1:0]  col;
        logic [lae_pkg::ROW_AW-1:0] row;
        logic                       cell_in;
    } cell_req_t;

    typedef struct packed {
        logic [1:0] resp_kind;
        logic       cell_out;
        logic       range_error;
    } cell_resp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                          cfg_we;
    logic [lae_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lae_pkg::CFG_DATA_W-1:0] cfg_data;

    lae_req_if  req_ch ();
    lae_resp_if resp_ch ();

    life_automaton_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .resp      (resp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Board predictor: shadow registers, two banks and the current bank.
    // ------------------------------------------------------------------
    logic [lae_pkg::WIDTH_REG_W-1:0]  width_reg  = lae_pkg::WIDTH_RESET;
    logic [lae_pkg::HEIGHT_REG_W-1:0] height_reg = lae_pkg::HEIGHT_RESET;
    bit                               live_bank  = 1'b0;
    bit board_mem [2][lae_pkg::MAX_HEIGHT][lae_pkg::MAX_WIDTH];

    cell_req_t  req_pending_q [$];   // requests waiting to be driven
    cell_resp_t cell_resp_due_q [$]; // responses owed by the engine

    int unsigned mismatch_count = 0;
    int unsigned items_queued   = 0;
    int          send_idle_pct  = 26;
    int          recv_idle_pct  = 78;
    int          stall_cycles   = 0;

    // Zero acts as one, anything above the limit saturates.
    function automatic int board_cols();
        if (width_reg == 0) return 1;
        if (width_reg > lae_pkg::MAX_WIDTH) return lae_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int board_rows();
        if (height_reg == 0) return 1;
        if (height_reg > lae_pkg::MAX_HEIGHT) return lae_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic int live_at(bit b, int x, int y, int w, int h);
        if (x < 0 || y < 0 || x >= w || y >= h) return 0;
        return board_mem[b][y][x];
    endfunction

    // Build the next generation in the idle bank, then swap banks.
    // Everything outside the board in the new bank ends up dead.
    task automatic next_generation();
        int w;
        int h;
        int n;
        bit src;
        w   = board_cols();
        h   = board_rows();
        src = live_bank;
        for (int y = 0; y < lae_pkg::MAX_HEIGHT; y++)
            for (int x = 0; x < lae_pkg::MAX_WIDTH; x++)
                board_mem[!src][y][x] = 1'b0;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                n = 0;
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                        if (dx != 0 || dy != 0)
                            n += live_at(src, x + dx, y + dy, w, h);
                if (board_mem[src][y][x])
                    board_mem[!src][y][x] = (n == 2 || n == 3);
                else
                    board_mem[!src][y][x] = (n == 3);
            end
        end
        live_bank = !src;
    endtask

    task automatic predict_cell_resp(input cell_req_t rq, output cell_resp_t rs);
        rs.resp_kind   = rq.req_type;
        rs.cell_out    = 1'b0;
        rs.range_error = 1'b0;
        if (rq.req_type == lae_pkg::REQ_WRITE || rq.req_type == lae_pkg::REQ_READ)
        begin
            if (rq.col >= board_cols() || rq.row >= board_rows())
                rs.range_error = 1'b1;
            else if (rq.req_type == lae_pkg::REQ_WRITE)
                board_mem[live_bank][rq.row][rq.col] = rq.cell_in;
            else
                rs.cell_out = board_mem[live_bank][rq.row][rq.col];
        end
        else if (rq.req_type == lae_pkg::REQ_ADVANCE)
        begin
            next_generation();
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: hold each transaction until accepted, predict on
    // acceptance, then present the next pending item or idle at random.
    // ------------------------------------------------------------------
    cell_req_t  drv_req;
    cell_resp_t drv_resp;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_cell_resp(drv_req, drv_resp);
                cell_resp_due_q = {cell_resp_due_q, drv_resp};
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    drv_req = req_pending_q.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= drv_req.req_type;
                    req_ch.col      <= drv_req.col;
                    req_ch.row      <= drv_req.row;
                    req_ch.cell_in  <= drv_req.cell_in;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: check each taken transaction against the oldest
    // prediction; toggle ready at random.
    // ------------------------------------------------------------------
    cell_resp_t mon_got;
    cell_resp_t mon_exp;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            resp_ch.ready <= 1'b0;
        end
        else
        begin
            if (resp_ch.valid && resp_ch.ready)
            begin
                mon_got.resp_kind   = resp_ch.resp_kind;
                mon_got.cell_out    = resp_ch.cell_out;
                mon_got.range_error = resp_ch.range_error;
                if (cell_resp_due_q.size() == 0)
                begin
                    $display("%0t: unexpected response, got kind=%0d cell=%0d err=%0d",
                             $time, mon_got.resp_kind, mon_got.cell_out,
                             mon_got.range_error);
                    mismatch_count++;
                end
                else
                begin
                    mon_exp = cell_resp_due_q.pop_front();
                    if (mon_got.resp_kind !== mon_exp.resp_kind)
                    begin
                        $display("%0t: resp_kind expected %0d, got %0d",
                                 $time, mon_exp.resp_kind, mon_got.resp_kind);
                        mismatch_count++;
                    end
                    if (mon_got.cell_out !== mon_exp.cell_out)
                    begin
                        $display("%0t: cell_out expected %0d, got %0d",
                                 $time, mon_exp.cell_out, mon_got.cell_out);
                        mismatch_count++;
                    end
                    if (mon_got.range_error !== mon_exp.range_error)
                    begin
                        $display("%0t: range_error expected %0d, got %0d",
                                 $time, mon_exp.range_error, mon_got.range_error);
                        mismatch_count++;
                    end
                end
            end
            resp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: abandon the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[life_automaton_engine] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_req(input logic [1:0] kind, input int c, input int r, input bit v);
        cell_req_t rq;
        rq.req_type = kind;
        rq.col      = c[lae_pkg::COL_W-1:0];
        rq.row      = r[lae_pkg::ROW_AW-1:0];
        rq.cell_in  = v;
        req_pending_q = {req_pending_q, rq};
        items_queued++;
    endtask

    // Queue a request, and now and then a fully random one after it.
    task automatic queue_req_noisy(input logic [1:0] kind, input int c, input int r,
                                   input bit v);
        queue_req(kind, c, r, v);
        if ($urandom_range(0, 6) == 0)
            queue_req(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                      $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    endtask

    // Wait until every item is accepted and answered, then let the engine settle.
    // Look between edges so that the driver's updates of this edge are visible.
    task automatic settle();
        while (req_pending_q.size() > 0 || req_ch.valid || cell_resp_due_q.size() > 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both size registers; only call with the engine idle.
    task automatic set_board(input int w_val, input int h_val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= lae_pkg::CFG_BOARD_WIDTH;
        cfg_data  <= w_val[lae_pkg::CFG_DATA_W-1:0];
        width_reg  = w_val[lae_pkg::WIDTH_REG_W-1:0];
        @(posedge clk);
        cfg_index <= lae_pkg::CFG_BOARD_HEIGHT;
        cfg_data  <= h_val[lae_pkg::CFG_DATA_W-1:0];
        height_reg = h_val[lae_pkg::HEIGHT_REG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Pick the idling pattern from how far the stimulus has got.
    task automatic pick_idling();
        if (items_queued < 33)
        begin
            send_idle_pct = 26;
            recv_idle_pct = 78;
        end
        else if (items_queued < 66)
        begin
            send_idle_pct = 78;
            recv_idle_pct = 26;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int w_val;
        int h_val;
        int w;
        int h;
        int ww;
        int wh;
        int ox;
        int oy;
        int sel;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = lae_pkg::CFG_BOARD_WIDTH;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = lae_pkg::REQ_WRITE;
        req_ch.col      = '0;
        req_ch.row      = '0;
        req_ch.cell_in  = 1'b0;
        resp_ch.ready   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset size (150 x 60): cleared board, far corner, just off each edge,
        // and the unused request code.
        queue_req(lae_pkg::REQ_READ,    0,   0,  1'b0);
        queue_req(lae_pkg::REQ_WRITE,   149, 59, 1'b1);
        queue_req(lae_pkg::REQ_READ,    149, 59, 1'b0);
        queue_req(lae_pkg::REQ_WRITE,   150, 10, 1'b1);
        queue_req(lae_pkg::REQ_READ,    5,   60, 1'b0);
        queue_req(REQ_UNUSED,           255, 63, 1'b1);
        settle();

        // Full board: an L in the far corner grows to a block, a blinker on
        // the top edge flips, the lone cell from before dies.
        set_board(lae_pkg::MAX_WIDTH, lae_pkg::MAX_HEIGHT);
        queue_req(lae_pkg::REQ_WRITE,   255, 63, 1'b1);
        queue_req(lae_pkg::REQ_WRITE,   254, 63, 1'b1);
        queue_req(lae_pkg::REQ_WRITE,   255, 62, 1'b1);
        queue_req(lae_pkg::REQ_WRITE,   0,   1,  1'b1);
        queue_req(lae_pkg::REQ_WRITE,   1,   1,  1'b1);
        queue_req(lae_pkg::REQ_WRITE,   2,   1,  1'b1);
        queue_req(lae_pkg::REQ_ADVANCE, 128, 32, 1'b1);
        queue_req(lae_pkg::REQ_READ,    254, 62, 1'b0);
        queue_req(lae_pkg::REQ_READ,    1,   0,  1'b0);
        queue_req(lae_pkg::REQ_READ,    0,   1,  1'b0);
        queue_req(lae_pkg::REQ_READ,    149, 59, 1'b0);
        queue_req(lae_pkg::REQ_ADVANCE, 0,   0,  1'b0);
        queue_req(lae_pkg::REQ_READ,    0,   1,  1'b0);
        settle();

        // Zero sizes act as a single cell; the lone cell dies.
        set_board(0, 0);
        queue_req(lae_pkg::REQ_WRITE,   0,   0,  1'b1);
        queue_req(lae_pkg::REQ_READ,    1,   0,  1'b0);
        queue_req(lae_pkg::REQ_ADVANCE, 0,   0,  1'b0);
        queue_req(lae_pkg::REQ_READ,    0,   0,  1'b0);
        settle();

        // Oversized values saturate to the full board.
        set_board(511, 127);
        queue_req(lae_pkg::REQ_READ,    255, 63, 1'b0);
        settle();

        // Random phases: clustered writes, generations and reads in a small
        // window, so that patterns actually evolve and get observed.
        while (items_queued < 85)
        begin
            pick_idling();
            sel = $urandom_range(0, 9);
            if (sel < 2)
            begin
                case ($urandom_range(0, 3))
                    0:       w_val = 0;
                    1:       w_val = 1;
                    2:       w_val = lae_pkg::MAX_WIDTH;
                    default: w_val = 511;
                endcase
            end
            else if (sel < 3)
            begin
                w_val = $urandom_range(0, 511);
            end
            else
            begin
                w_val = $urandom_range(3, 12);
            end
            sel = $urandom_range(0, 9);
            if (sel < 2)
            begin
                case ($urandom_range(0, 3))
                    0:       h_val = 0;
                    1:       h_val = 1;
                    2:       h_val = lae_pkg::MAX_HEIGHT;
                    default: h_val = 127;
                endcase
            end
            else if (sel < 3)
            begin
                h_val = $urandom_range(0, 511);
            end
            else
            begin
                h_val = $urandom_range(3, 10);
            end
            set_board(w_val, h_val);

            w  = board_cols();
            h  = board_rows();
            ww = (w < 8) ? w : 8;
            wh = (h < 8) ? h : 8;
            ox = $urandom_range(0, w - ww);
            oy = $urandom_range(0, h - wh);

            repeat ($urandom_range(5, 10))
                queue_req_noisy(lae_pkg::REQ_WRITE, ox + $urandom_range(0, ww - 1),
                                oy + $urandom_range(0, wh - 1),
                                $urandom_range(0, 9) < 7);
            repeat ($urandom_range(1, 3))
            begin
                queue_req_noisy(lae_pkg::REQ_ADVANCE, $urandom_range(0, 255),
                                $urandom_range(0, 63), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(2, 5))
                    queue_req_noisy(lae_pkg::REQ_READ, ox + $urandom_range(0, ww - 1),
                                    oy + $urandom_range(0, wh - 1),
                                    1'($urandom_range(0, 1)));
            end
            settle();
        end

        // Drain, then watch a little longer for stray responses.
        settle();
        repeat (80) @(posedge clk);
        if (mismatch_count == 0)
            $display("[life_automaton_engine] OK");
        else
            $display("[life_automaton_engine] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/lae_pkg.sv
rtl/lae_if.sv
rtl/lae_ram.sv
rtl/lae_row_update.sv
rtl/life_automaton_engine.sv
sim/tb_top.sv
